// ===== sv/icc_profile_app2_segmenter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ICC_PROFILE_APP2_SEGMENTER_DEFINES_SVH
`define ICC_PROFILE_APP2_SEGMENTER_DEFINES_SVH

// Concurrent assertion, disabled while reset is high
`define ICC_SEG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that is also checked across reset
`define ICC_SEG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== sv/icc_seg_pkg.sv =====
package icc_seg_pkg;

   // Profile bytes carried by one full segment
   localparam logic [15:0] SEG_BYTES    = 16'd65519;
   // Header bytes ahead of the first data byte of a segment
   localparam int          HDR_LEN      = 18;
   localparam int          HDR_IDX_W    = $clog2(HDR_LEN + 1);
   localparam logic [15:0] LENGTH_EXTRA = 16'd16;
   localparam logic [7:0]  MARKER_PFX   = 8'hFF;
   localparam logic [7:0]  APP2_MARKER  = 8'hE2;

   // Header byte positions
   localparam logic [HDR_IDX_W-1:0] HP_MARKER_PFX = HDR_IDX_W'(0);
   localparam logic [HDR_IDX_W-1:0] HP_MARKER     = HDR_IDX_W'(1);
   localparam logic [HDR_IDX_W-1:0] HP_LEN_HI     = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] HP_LEN_LO     = HDR_IDX_W'(3);
   localparam logic [HDR_IDX_W-1:0] HP_IDENT      = HDR_IDX_W'(4);
   localparam logic [HDR_IDX_W-1:0] HP_SEG_NUM    = HDR_IDX_W'(16);
   localparam logic [HDR_IDX_W-1:0] HP_SEG_CNT    = HDR_IDX_W'(17);
   localparam logic [HDR_IDX_W-1:0] HP_DONE       = HDR_IDX_W'(HDR_LEN);

   // Profile identifier plus terminator
   localparam logic [7:0] ICC_IDENT [12] = '{
      8'h49, 8'h43, 8'h43, 8'h5F, 8'h50, 8'h52,
      8'h4F, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h00
   };

   // Queue between classifier and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One classified profile byte
   typedef struct packed {
      logic [7:0]  data;
      logic        hdr;      // opens a segment
      logic [15:0] seglen;   // chunk size + 16
      logic [7:0]  seg_num;
   } icc_item_type;

   // Queue status seen by the emitter
   typedef struct packed {
      logic         empty;
      icc_item_type head;
   } icc_q_stat_type;

   // Low 8 bits of ceil(len / 65519); 65519 = 2^16 - 17, so the quotient
   // is (x >> 16) or one more.
   function automatic logic [7:0] seg_count(input logic [23:0] len);
      logic [24:0] x;
      logic [8:0]  q0;
      logic [16:0] r;
      logic [8:0]  q;
      x  = {1'b0, len} + 25'(SEG_BYTES - 16'd1);
      q0 = x[24:16];
      r  = {1'b0, x[15:0]} + {4'b0, q0, 4'b0} + {8'b0, q0};
      q  = (r >= {1'b0, SEG_BYTES}) ? q0 + 9'd1 : q0;
      return q[7:0];
   endfunction

   // Header byte at a given position
   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                           input logic [15:0] seglen,
                                           input logic [7:0]  seg_num,
                                           input logic [7:0]  seg_cnt);
      logic [HDR_IDX_W-1:0] rel;
      logic [7:0]           b;
      rel = idx - HP_IDENT;
      if (idx == HP_MARKER_PFX)      b = MARKER_PFX;
      else if (idx == HP_MARKER)     b = APP2_MARKER;
      else if (idx == HP_LEN_HI)     b = seglen[15:8];
      else if (idx == HP_LEN_LO)     b = seglen[7:0];
      else if (idx == HP_SEG_NUM)    b = seg_num;
      else if (idx == HP_SEG_CNT)    b = seg_cnt;
      else if (idx < HP_SEG_NUM)     b = ICC_IDENT[rel[3:0]];
      else                           b = 8'h00;
      return b;
   endfunction

endpackage

// ===== sv/icc_profile_app2_segmenter.sv =====
// Channel  | Ports                                   | Direction
// req      | req_valid/req_ready, req_profile_byte   | in
// rsp      | rsp_valid/rsp_ready, rsp_out_byte,      | out
//          |   rsp_is_header, rsp_last_of_run        |
// csr      | csr_valid/csr_ready, csr_profile_length | in
//
// The emitter sends one byte per cycle while rsp_ready is high and the queue is not
// empty; a byte that opens a segment goes out as 18 header bytes, then the data byte.
// A 4-entry queue lets the classifier take bytes while a header is emitted.
// Bytes past the profile length are taken and give nothing.
// Synchronous active-high reset; csr_ready is always high.
module icc_profile_app2_segmenter
   import icc_seg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_profile_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_header,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_profile_length
);

   logic           q_full;
   logic           push;
   logic           pop;
   icc_item_type   push_item;
   icc_q_stat_type q_stat;
   logic [7:0]     seg_cnt;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;

   // Classifier
   icc_seg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_profile_length (csr_profile_length),
      .req_fire           (req_valid && req_ready),
      .req_profile_byte   (req_profile_byte),
      .push               (push),
      .push_item          (push_item),
      .seg_cnt            (seg_cnt)
   );

   // Decoupling queue
   icc_seg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .stat      (q_stat)
   );

   // Segment emitter
   icc_seg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .stat            (q_stat),
      .seg_cnt         (seg_cnt),
      .pop             (pop),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_header   (rsp_is_header),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== sv/icc_seg_front.sv =====
module icc_seg_front
   import icc_seg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [23:0]  csr_profile_length,
   input  logic         req_fire,
   input  logic [7:0]   req_profile_byte,
   output logic         push,
   output icc_item_type push_item,
   output logic [7:0]   seg_cnt
);

   logic [23:0] length_ff,   length_in;
   logic [23:0] consumed_ff, consumed_in;
   logic [15:0] chunk_pos_ff, chunk_pos_in;
   logic [7:0]  seg_num_ff,  seg_num_in;
   logic [7:0]  seg_cnt_ff,  seg_cnt_in;

   logic        keep;
   logic [23:0] remaining;
   logic [15:0] chunk;
   logic [15:0] chunk_pos_inc;

   // Classify the incoming byte
   always_comb begin
      keep      = consumed_ff < length_ff;
      remaining = length_ff - consumed_ff;
      chunk     = (remaining > {8'b0, SEG_BYTES}) ? SEG_BYTES : remaining[15:0];
      push      = req_fire && keep;
      push_item.data    = req_profile_byte;
      push_item.hdr     = (chunk_pos_ff == 16'd0);
      push_item.seglen  = chunk + LENGTH_EXTRA;
      push_item.seg_num = seg_num_ff;
   end

   // Position tracking; a length write restarts it
   always_comb begin
      chunk_pos_inc = chunk_pos_ff + 16'd1;
      length_in     = length_ff;
      consumed_in   = consumed_ff;
      chunk_pos_in  = chunk_pos_ff;
      seg_num_in    = seg_num_ff;
      seg_cnt_in    = seg_cnt_ff;
      if (csr_valid) begin
         length_in    = csr_profile_length;
         seg_cnt_in   = seg_count(csr_profile_length);
         consumed_in  = 24'd0;
         chunk_pos_in = 16'd0;
         seg_num_in   = 8'd1;
      end else if (push) begin
         consumed_in = consumed_ff + 24'd1;
         if (chunk_pos_inc >= SEG_BYTES) begin
            chunk_pos_in = 16'd0;
            seg_num_in   = seg_num_ff + 8'd1;
         end else begin
            chunk_pos_in = chunk_pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= 24'd0;
         consumed_ff  <= 24'd0;
         chunk_pos_ff <= 16'd0;
         seg_num_ff   <= 8'd1;
         seg_cnt_ff   <= 8'd0;
      end else begin
         length_ff    <= length_in;
         consumed_ff  <= consumed_in;
         chunk_pos_ff <= chunk_pos_in;
         seg_num_ff   <= seg_num_in;
         seg_cnt_ff   <= seg_cnt_in;
      end
   end

   assign seg_cnt = seg_cnt_ff;

endmodule

// ===== sv/icc_seg_fifo.sv =====
module icc_seg_fifo
   import icc_seg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  icc_item_type   push_item,
   input  logic           pop,
   output logic           full,
   output icc_q_stat_type stat
);

   icc_item_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       fill_ff,   fill_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + (QUEUE_AW+1)'(1);
      if (!push && pop) fill_in = fill_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   assign full       = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign stat.head  = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/icc_seg_back.sv =====
module icc_seg_back
   import icc_seg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  icc_q_stat_type stat,
   input  logic [7:0]     seg_cnt,
   output logic           pop,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_is_header,
   output logic           rsp_last_of_run
);

   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff,  byte_in;
   logic                 hdr_ff,   hdr_in;
   logic                 last_ff,  last_in;
   logic [HDR_IDX_W-1:0] idx_ff,   idx_in;
   logic                 advance;
   logic                 emit_hdr;

   // Next output byte from the queue head
   always_comb begin
      advance  = !valid_ff || rsp_ready;
      emit_hdr = stat.head.hdr && (idx_ff != HP_DONE);
      pop      = advance && !stat.empty && !emit_hdr;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      hdr_in   = hdr_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (advance) begin
         valid_in = !stat.empty;
         if (!stat.empty) begin
            if (emit_hdr) begin
               byte_in = hdr_byte(idx_ff, stat.head.seglen, stat.head.seg_num, seg_cnt);
               hdr_in  = 1'b1;
               last_in = 1'b0;
               idx_in  = idx_ff + HDR_IDX_W'(1);
            end else begin
               byte_in = stat.head.data;
               hdr_in  = 1'b0;
               last_in = 1'b1;
               idx_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      hdr_ff  <= hdr_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_header   = hdr_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== sv/icc_seg_checker.sv =====
`include "icc_profile_app2_segmenter_defines.svh"

module icc_seg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_header,
   input logic       rsp_last_of_run
);

   logic [9:0] rsp_payload;

   assign rsp_payload = {rsp_out_byte, rsp_is_header, rsp_last_of_run};

   // A stalled transaction stays up
   `ICC_SEG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // Its payload holds while stalled
   `ICC_SEG_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload))

   // Header bytes never close a run, data bytes always do
   `ICC_SEG_ASSERT(a_last_is_data, clock, reset, rsp_valid |-> (rsp_is_header != rsp_last_of_run))

   // Nothing is offered right after reset
   `ICC_SEG_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

bind icc_profile_app2_segmenter icc_seg_checker u_icc_seg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_is_header   (rsp_is_header),
   .rsp_last_of_run (rsp_last_of_run)
);
